@@ hw/rtl/pgw_pkg.sv @@
// Shared types, constants and helpers for the three-level page table walker.
`default_nettype none

package pgw_pkg;

    localparam int NUM_TABLES_DEF    = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int ENTRY_W           = 31;
    localparam int FIELD_W           = 27;
    localparam int ADDR_W            = 48;
    localparam int OFS_W             = 21;
    localparam int SHIFT_PDP         = 30;
    localparam int SHIFT_TOP         = 39;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_PRESENT = 3'd1,
        ST_SAME        = 3'd2,
        ST_CONFLICT    = 3'd3,
        ST_NO_TABLE    = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        OP_TRANSLATE = 1'b0,
        OP_MAP       = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK_TOP,
        S_CHK_PDP,
        S_CHK_PD,
        S_DECIDE,
        S_WR_PD,
        S_WR_PDP,
        S_WR_TOP
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [ADDR_W-1:0]   virt_addr;
        logic [ADDR_W-1:0]   phys_addr_in;
        logic                write_through;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   phys_addr_out;
        status_t             status;
    } res_t;

    // entry: bit 0 present, 1 writeable, 2 write-through, 3 page size, 30:4 field
    function automatic logic [ENTRY_W-1:0] dir_entry(input logic [FIELD_W-1:0] tbl);
        dir_entry = {tbl, 1'b0, 1'b0, 1'b1, 1'b1};
    endfunction

    function automatic logic [ENTRY_W-1:0] leaf_entry(input logic [FIELD_W-1:0] frame,
                                                     input logic wt);
        leaf_entry = {frame, 1'b1, wt, 1'b1, 1'b1};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pgw_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module pgw_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32768
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/pgw_walk_ctrl.sv @@
// Walk sequencer: clearing pass, table reads, allocation and entry writes.
`default_nettype none

module pgw_walk_ctrl #(
    parameter int NUM_TABLES = pgw_pkg::NUM_TABLES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pgw_pkg::item_t       in_item,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output pgw_pkg::res_t             res,
    output logic                      ram_we,
    output logic [$clog2(NUM_TABLES)+pgw_pkg::IDX_W-1:0] ram_addr,
    output logic [pgw_pkg::ENTRY_W-1:0] ram_wdata,
    input  wire logic [pgw_pkg::ENTRY_W-1:0] ram_rdata
);

    import pgw_pkg::*;

    localparam int TW    = $clog2(NUM_TABLES);
    localparam int AW    = TW + IDX_W;
    localparam int DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
    localparam int CW    = $clog2(NUM_TABLES + 1);

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]       nf_reg, nf_next;
    item_t               item_reg, item_next;
    logic                have_pdp_reg, have_pdp_next;
    logic                have_pd_reg, have_pd_next;
    logic                have_leaf_reg, have_leaf_next;
    logic [TW-1:0]       t_pdp_reg, t_pdp_next;
    logic [TW-1:0]       t_pd_reg, t_pd_next;
    logic [FIELD_W-1:0]  leaf_frame_reg, leaf_frame_next;

    logic [IDX_W-1:0]    in_top, i_top, i_pdp, i_pd;
    logic [FIELD_W-1:0]  rd_field, frame;
    logic                rd_dir_ok;
    logic [1:0]          need;
    logic [CW-1:0]       left, nf_plus1;

    assign in_top    = in_item.virt_addr[SHIFT_TOP +: IDX_W];
    assign i_top     = item_reg.virt_addr[SHIFT_TOP +: IDX_W];
    assign i_pdp     = item_reg.virt_addr[SHIFT_PDP +: IDX_W];
    assign i_pd      = item_reg.virt_addr[OFS_W +: IDX_W];
    assign frame     = item_reg.phys_addr_in[ADDR_W-1:OFS_W];
    assign rd_field  = ram_rdata[ENTRY_W-1:4];
    // out-of-pool table indexes count as not present
    assign rd_dir_ok = ram_rdata[0] && (rd_field < FIELD_W'(NUM_TABLES));
    assign need      = have_pdp_reg ? (have_pd_reg ? 2'd0 : 2'd1) : 2'd2;
    assign left      = (nf_reg < CW'(NUM_TABLES)) ? (CW'(NUM_TABLES) - nf_reg) : '0;
    assign nf_plus1  = nf_reg + CW'(1);
    assign in_ready  = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            nf_reg      <= CW'(1);
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            nf_reg      <= nf_next;
        end
        item_reg       <= item_next;
        have_pdp_reg   <= have_pdp_next;
        have_pd_reg    <= have_pd_next;
        have_leaf_reg  <= have_leaf_next;
        t_pdp_reg      <= t_pdp_next;
        t_pd_reg       <= t_pd_next;
        leaf_frame_reg <= leaf_frame_next;
    end

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        nf_next         = nf_reg;
        item_next       = item_reg;
        have_pdp_next   = have_pdp_reg;
        have_pd_next    = have_pd_reg;
        have_leaf_next  = have_leaf_reg;
        t_pdp_next      = t_pdp_reg;
        t_pd_next       = t_pd_reg;
        leaf_frame_next = leaf_frame_reg;
        ram_we          = 1'b0;
        ram_addr        = {t_pd_reg, i_pd};
        ram_wdata       = leaf_entry(frame, item_reg.write_through);
        res_valid       = 1'b0;
        res.phys_addr_out = '0;
        res.status        = ST_NOT_PRESENT;

        case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                // root read issued straight from the incoming transfer
                ram_addr = {TW'(0), in_top};
                if (in_valid) begin
                    item_next      = in_item;
                    have_pdp_next  = 1'b0;
                    have_pd_next   = 1'b0;
                    have_leaf_next = 1'b0;
                    state_next     = S_CHK_TOP;
                end
            end
            S_CHK_TOP: begin
                ram_addr      = {rd_field[TW-1:0], i_pdp};
                have_pdp_next = rd_dir_ok;
                t_pdp_next    = rd_field[TW-1:0];
                state_next    = rd_dir_ok ? S_CHK_PDP : S_DECIDE;
            end
            S_CHK_PDP: begin
                ram_addr     = {rd_field[TW-1:0], i_pd};
                have_pd_next = rd_dir_ok;
                t_pd_next    = rd_field[TW-1:0];
                state_next   = rd_dir_ok ? S_CHK_PD : S_DECIDE;
            end
            S_CHK_PD: begin
                have_leaf_next  = ram_rdata[0];
                leaf_frame_next = rd_field;
                state_next      = S_DECIDE;
            end
            S_DECIDE: begin
                res_valid = 1'b1;
                if (item_reg.opcode == OP_TRANSLATE) begin
                    if (have_leaf_reg) begin
                        res.phys_addr_out = {leaf_frame_reg, item_reg.virt_addr[OFS_W-1:0]};
                        res.status        = ST_OK;
                    end
                    if (res_ready) begin
                        state_next = S_IDLE;
                    end
                end else if (have_leaf_reg) begin
                    res.phys_addr_out = {leaf_frame_reg, OFS_W'(0)};
                    res.status        = (leaf_frame_reg == frame) ? ST_SAME : ST_CONFLICT;
                    if (res_ready) begin
                        state_next = S_IDLE;
                    end
                end else if (CW'(need) > left) begin
                    res.status = ST_NO_TABLE;
                    if (res_ready) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    res.phys_addr_out = {frame, OFS_W'(0)};
                    res.status        = ST_OK;
                    if (res_ready) begin
                        if (!have_pdp_reg) begin
                            t_pdp_next = nf_reg[TW-1:0];
                            t_pd_next  = nf_plus1[TW-1:0];
                        end else if (!have_pd_reg) begin
                            t_pd_next = nf_reg[TW-1:0];
                        end
                        nf_next    = nf_reg + CW'(need);
                        state_next = S_WR_PD;
                    end
                end
            end
            S_WR_PD: begin
                ram_we     = 1'b1;
                state_next = have_pd_reg ? S_IDLE : S_WR_PDP;
            end
            S_WR_PDP: begin
                ram_we     = 1'b1;
                ram_addr   = {t_pdp_reg, i_pdp};
                ram_wdata  = dir_entry(FIELD_W'(t_pd_reg));
                state_next = have_pdp_reg ? S_IDLE : S_WR_TOP;
            end
            S_WR_TOP: begin
                ram_we     = 1'b1;
                ram_addr   = {TW'(0), i_top};
                ram_wdata  = dir_entry(FIELD_W'(t_pdp_reg));
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/three_level_page_table_walker_core.sv @@
// Top level: stream ports, result output register, table store and walk sequencer.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser opcode; s_tdata va, pa, write-through
//  m_      | out | m_tvalid/m_tready  | m_tdata phys_addr_out, status
//
// An item passes through an accept state, one to three table reads (the single
// RAM port has a registered read), a decide state and up to three entry writes;
// reads and writes together never exceed four. After reset a clearing pass writes
// every entry with s_tready low. A stalled result waits in the output register;
// the walker only holds in its decide state when a second result finds that
// register still full.
`default_nettype none

module three_level_page_table_walker_core #(
    parameter int NUM_TABLES = pgw_pkg::NUM_TABLES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,   // [47:0] virt_addr, [95:48] phys_addr_in,
                                         // [96] write_through, [103:97] zero
    input  wire logic [0:0]   s_tuser,   // [0] opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata    // [47:0] phys_addr_out, [50:48] status,
                                         // [55:51] zero
);

    import pgw_pkg::*;

    localparam int AW    = $clog2(NUM_TABLES) + IDX_W;
    localparam int DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;

    item_t               in_item;
    res_t                res;
    logic                res_valid, res_ready;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic                m_valid_reg, m_valid_next;
    res_t                m_res_reg, m_res_next;

    assign in_item.opcode        = opcode_t'(s_tuser[0]);
    assign in_item.virt_addr     = s_tdata[47:0];
    assign in_item.phys_addr_in  = s_tdata[95:48];
    assign in_item.write_through = s_tdata[96];

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_res_reg.status, m_res_reg.phys_addr_out};

    pgw_walk_ctrl #(
        .NUM_TABLES (NUM_TABLES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    pgw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
